// ----- sv/rotate_translate_points_defines.svh -----
// ============================================================================
// rotate_translate_points_defines.svh
// Assertion macros shared by the rotate and translate block.
// ============================================================================
`ifndef ROTATE_TRANSLATE_POINTS_DEFINES_SVH
`define ROTATE_TRANSLATE_POINTS_DEFINES_SVH

// Same-cycle implication under the synchronous active-low reset.
`define RTP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rotate_translate_points: implication check failed");

// Next-cycle implication under the synchronous active-low reset.
`define RTP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rotate_translate_points: next-cycle check failed");

`endif

// ----- sv/rtp_pkg.sv -----
// ============================================================================
// rtp_pkg
// Types, constants and helpers of the rotate and translate block.
// ============================================================================
package rtp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS     = 14;
    localparam int TRIG_BITS      = 17;
    localparam int CFG_INDEX_W    = 3;

    // Angles in sixteenths of a degree.
    localparam logic [15:0] FULL_TURN    = 16'd5760;
    localparam logic [15:0] QUARTER_TURN = 16'd1440;
    localparam logic [15:0] EIGHTH_TURN  = 16'd720;
    // Three full turns make every effective angle non-negative.
    localparam logic [16:0] ANGLE_BIAS   = 17'd17280;
    // One sixteenth of a degree in radians, Q30.
    localparam logic [20:0] RAD_Q30_PER_STEP = 21'd1171271;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic signed [TRIG_BITS-1:0] COS_RESET = 17'sd32768;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FEATURE_ANGLE    = 3'd0,
        REG_MAP_ANGLE        = 3'd1,
        REG_ANGLE_FROM_NORTH = 3'd2,
        REG_CENTER_X         = 3'd3,
        REG_CENTER_Y         = 3'd4
    } rtp_reg_t;

    // Sine and cosine sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MOD,
        ST_QUAD,
        ST_OCT,
        ST_MUL,
        ST_DIV
    } trig_state_t;

    // Series steps: even steps multiply, odd steps divide by a constant.
    localparam logic [3:0] STEP_X2      = 4'd0;
    localparam logic [3:0] STEP_SIN_DIV = 4'd1;
    localparam logic [3:0] STEP_SIN_MUL = 4'd6;
    localparam logic [3:0] STEP_COS_DIV = 4'd7;
    localparam logic [3:0] STEP_LAST    = 4'd13;

    // Reciprocal of the Taylor divisor for each divide step, rounded up.
    // With the matching shift the quotient is exact for any 30-bit dividend.
    function automatic logic [30:0] step_recip(input logic [3:0] step);
        logic [30:0] r;
        unique case (step)
            4'd1:    r = 31'd1636178018;  // 2^36 / 42
            4'd3:    r = 31'd1717986919;  // 2^35 / 20
            4'd5:    r = 31'd1431655766;  // 2^33 / 6
            4'd7:    r = 31'd1227133514;  // 2^36 / 56
            4'd9:    r = 31'd1145324613;  // 2^35 / 30
            4'd11:   r = 31'd1431655766;  // 2^34 / 12
            default: r = 31'd1073741824;  // 2^31 / 2
        endcase
        return r;
    endfunction

    // Right shift that goes with the reciprocal of each divide step.
    function automatic logic [5:0] step_shift(input logic [3:0] step);
        logic [5:0] s;
        unique case (step)
            4'd1:    s = 6'd36;
            4'd3:    s = 6'd35;
            4'd5:    s = 6'd33;
            4'd7:    s = 6'd36;
            4'd9:    s = 6'd35;
            4'd11:   s = 6'd34;
            default: s = 6'd31;
        endcase
        return s;
    endfunction

endpackage

// ----- sv/rotate_translate_points.sv -----
// An accepted point passes the capture, products, scale and saturate stages to
// its result. Throughput: one point per cycle while m_ready is high and no
// update runs; the four coordinate products run in one stage. A write to a
// known register starts a sine and cosine update (angle reduction by subtraction,
// then one shared multiply per series step); s_ready is low meanwhile.
// Reset (aresetn, synchronous, active low) clears the pipeline, sets the
// registers to their reset values and the rotation to zero degrees.
// ============================================================================
// rotate_translate_points
// Rotates outline points by a configured angle and adds the screen center.
// ============================================================================
`include "rotate_translate_points_defines.svh"

module rotate_translate_points #(
    parameter int COORD_BITS = rtp_pkg::COORD_BITS_DEF,
    localparam int CFG_DATA_W = (COORD_BITS > rtp_pkg::ANGLE_BITS) ?
                                COORD_BITS : rtp_pkg::ANGLE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rtp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [COORD_BITS-1:0]    s_point_x,
    input  logic signed [COORD_BITS-1:0]    s_point_y,
    input  logic                            s_last_point,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [COORD_BITS-1:0]    m_screen_x,
    output logic signed [COORD_BITS-1:0]    m_screen_y,
    output logic                            m_last_out
);
    import rtp_pkg::*;

    localparam int PW = COORD_BITS + TRIG_BITS;
    localparam int SW = COORD_BITS + TRIG_BITS + 1;
    localparam int RW = COORD_BITS + 3;
    localparam int CW = COORD_BITS + 4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [ANGLE_BITS-1:0] feature_angle_reg;
    logic signed [ANGLE_BITS-1:0] map_angle_reg;
    logic                         from_north_reg;
    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic                         cfg_fire;
    logic                         cfg_known;
    logic                         cfg_start;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == REG_FEATURE_ANGLE) || (cfg_index == REG_MAP_ANGLE) ||
                       (cfg_index == REG_ANGLE_FROM_NORTH) || (cfg_index == REG_CENTER_X) ||
                       (cfg_index == REG_CENTER_Y);
    assign cfg_start = cfg_fire && cfg_known;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feature_angle_reg <= '0;
            map_angle_reg     <= '0;
            from_north_reg    <= 1'b1;
            center_x_reg      <= '0;
            center_y_reg      <= '0;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_FEATURE_ANGLE:    feature_angle_reg <= cfg_data[ANGLE_BITS-1:0];
                REG_MAP_ANGLE:        map_angle_reg     <= cfg_data[ANGLE_BITS-1:0];
                REG_ANGLE_FROM_NORTH: from_north_reg    <= cfg_data[0];
                REG_CENTER_X:         center_x_reg      <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:         center_y_reg      <= cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sine and cosine sequencer
    // ------------------------------------------------------------------
    trig_state_t state_reg, state_next;
    logic [15:0] ang_reg;
    logic [1:0]  quad_reg;
    logic        swap_reg;
    logic [3:0]  step_reg;
    logic [29:0] x_reg, x2_reg, p_reg;
    logic [30:0] t_reg;
    logic [16:0] sin_b_reg;
    logic signed [TRIG_BITS-1:0] sine_reg, cosine_reg;
    logic        trig_busy;

    logic signed [14:0] eff_angle;
    logic [16:0] ang_biased;
    logic [9:0]  oct_b;
    logic [30:0] oct_x;
    logic [29:0] mul_a;
    logic [30:0] mul_b;
    logic [60:0] mul_p;
    logic [29:0] mul_q;
    logic [30:0] sin_round;
    logic [5:0]  div_shift;
    logic [60:0] div_shifted;
    logic [29:0] div_quo;
    logic [30:0] t_new;
    logic [31:0] cos_round;
    logic [16:0] cos_fresh;
    logic [16:0] s_sel, c_sel;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = ST_IDLE;
            ST_LOAD:  state_next = ST_MOD;
            ST_MOD:   if (ang_reg < FULL_TURN) state_next = ST_QUAD;
            ST_QUAD:  if (ang_reg < QUARTER_TURN) state_next = ST_OCT;
            ST_OCT:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   state_next = (step_reg == STEP_LAST) ? ST_IDLE : ST_MUL;
        endcase
        if (cfg_start) state_next = ST_LOAD;
    end

    // Sequencer outputs.
    always_comb begin
        trig_busy = (state_reg != ST_IDLE);
    end

    // Effective angle, octant reduction and the shared arithmetic.
    // A divide step multiplies by the rounded-up reciprocal and shifts.
    always_comb begin
        eff_angle  = from_north_reg ?
                     ({map_angle_reg[ANGLE_BITS-1], map_angle_reg} -
                      {feature_angle_reg[ANGLE_BITS-1], feature_angle_reg}) :
                     (15'sd1440 - {feature_angle_reg[ANGLE_BITS-1], feature_angle_reg});
        ang_biased = {{2{eff_angle[14]}}, eff_angle} + ANGLE_BIAS;
        oct_b      = (ang_reg > EIGHTH_TURN) ? 10'(QUARTER_TURN - ang_reg) : ang_reg[9:0];
        oct_x      = 31'({oct_b, 21'd0} >> 21) * RAD_Q30_PER_STEP;
        if (state_reg == ST_DIV) begin
            mul_a = ((step_reg == STEP_SIN_DIV) || (step_reg == STEP_COS_DIV)) ?
                    x2_reg : p_reg;
            mul_b = step_recip(step_reg);
        end else begin
            mul_a = ((step_reg == STEP_X2) || (step_reg == STEP_SIN_MUL)) ? x_reg : x2_reg;
            mul_b = (step_reg == STEP_X2) ? {1'b0, x_reg} : t_reg;
        end
        mul_p       = mul_a * mul_b;
        mul_q       = mul_p[59:30];
        sin_round   = {1'b0, mul_q} + 31'h4000;
        div_shift   = step_shift(step_reg);
        div_shifted = mul_p >> div_shift;
        div_quo     = div_shifted[29:0];
        t_new       = Q30_ONE - {1'b0, div_quo};
        cos_round   = {1'b0, t_new} + 32'h4000;
        cos_fresh   = cos_round[31:15];
        s_sel       = swap_reg ? cos_fresh : sin_b_reg;
        c_sel       = swap_reg ? sin_b_reg : cos_fresh;
    end

    // Sequencer registers.
    // The final swap needs the fresh cosine, so the quadrant fold uses it directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sine_reg   <= '0;
            cosine_reg <= COS_RESET;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_DIV) && (step_reg == STEP_LAST) && !cfg_start) begin
                // Fold the octant result into the quadrant.
                unique case (quad_reg)
                    2'd0: begin
                        sine_reg   <= s_sel;
                        cosine_reg <= c_sel;
                    end
                    2'd1: begin
                        sine_reg   <= c_sel;
                        cosine_reg <= -s_sel;
                    end
                    2'd2: begin
                        sine_reg   <= -s_sel;
                        cosine_reg <= -c_sel;
                    end
                    default: begin
                        sine_reg   <= -c_sel;
                        cosine_reg <= s_sel;
                    end
                endcase
            end
        end
    end

    // Angle reduction and the series steps.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: ;
            ST_LOAD: begin
                ang_reg <= ang_biased[15:0];
            end
            ST_MOD: begin
                quad_reg <= 2'd0;
                if (ang_reg >= FULL_TURN) ang_reg <= ang_reg - FULL_TURN;
            end
            ST_QUAD: begin
                if (ang_reg >= QUARTER_TURN) begin
                    ang_reg  <= ang_reg - QUARTER_TURN;
                    quad_reg <= quad_reg + 2'd1;
                end
            end
            ST_OCT: begin
                swap_reg <= (ang_reg > EIGHTH_TURN);
                x_reg    <= oct_x[29:0];
                step_reg <= STEP_X2;
            end
            ST_MUL: begin
                if (step_reg == STEP_X2) begin
                    x2_reg <= mul_q;
                end else if (step_reg == STEP_SIN_MUL) begin
                    sin_b_reg <= {1'b0, sin_round[30:15]};
                end else begin
                    p_reg <= mul_q;
                end
                step_reg <= step_reg + 4'd1;
            end
            ST_DIV: begin
                // One Horner term per divide step.
                t_reg <= t_new;
                if (step_reg != STEP_LAST) begin
                    step_reg <= step_reg + 4'd1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Point pipeline: capture, products, scale, translate and saturate
    // ------------------------------------------------------------------
    logic pipe_en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic l1_reg, l2_reg, l3_reg, l4_reg;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg;
    logic signed [PW-1:0] xc_reg, ys_reg, yc_reg, xs_reg;
    logic signed [RW-1:0] rx_reg, ry_reg;
    logic signed [COORD_BITS-1:0] sx_reg, sy_reg;
    logic signed [SW-1:0] sum_x, sum_y, rnd_x, rnd_y;
    logic signed [CW-1:0] tot_x, tot_y;
    logic signed [CW-1:0] sat_hi, sat_lo;
    logic signed [COORD_BITS-1:0] sat_x, sat_y;

    assign pipe_en = !v4_reg || m_ready;
    assign s_ready = pipe_en && !trig_busy;

    always_comb begin
        sum_x = {xc_reg[PW-1], xc_reg} + {ys_reg[PW-1], ys_reg};
        sum_y = {yc_reg[PW-1], yc_reg} - {xs_reg[PW-1], xs_reg};
        // Truncate toward zero: bias negative sums before the shift.
        rnd_x = sum_x + (sum_x[SW-1] ? SW'(32767) : SW'(0));
        rnd_y = sum_y + (sum_y[SW-1] ? SW'(32767) : SW'(0));
        tot_x = {{4{center_x_reg[COORD_BITS-1]}}, center_x_reg} + {rx_reg[RW-1], rx_reg};
        tot_y = {{4{center_y_reg[COORD_BITS-1]}}, center_y_reg} + {ry_reg[RW-1], ry_reg};
        sat_hi = {5'b00000, {(COORD_BITS-1){1'b1}}};
        sat_lo = {5'b11111, {(COORD_BITS-1){1'b0}}};
        if (tot_x > sat_hi) begin
            sat_x = sat_hi[COORD_BITS-1:0];
        end else if (tot_x < sat_lo) begin
            sat_x = sat_lo[COORD_BITS-1:0];
        end else begin
            sat_x = tot_x[COORD_BITS-1:0];
        end
        if (tot_y > sat_hi) begin
            sat_y = sat_hi[COORD_BITS-1:0];
        end else if (tot_y < sat_lo) begin
            sat_y = sat_lo[COORD_BITS-1:0];
        end else begin
            sat_y = tot_y[COORD_BITS-1:0];
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_valid && s_ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            x1_reg <= s_point_x;
            y1_reg <= s_point_y;
            l1_reg <= s_last_point;
            xc_reg <= x1_reg * cosine_reg;
            ys_reg <= y1_reg * sine_reg;
            yc_reg <= y1_reg * cosine_reg;
            xs_reg <= x1_reg * sine_reg;
            l2_reg <= l1_reg;
            rx_reg <= rnd_x[SW-1:15];
            ry_reg <= rnd_y[SW-1:15];
            l3_reg <= l2_reg;
            sx_reg <= sat_x;
            sy_reg <= sat_y;
            l4_reg <= l3_reg;
        end
    end

    assign m_valid    = v4_reg;
    assign m_screen_x = sx_reg;
    assign m_screen_y = sy_reg;
    assign m_last_out = l4_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RTP_ASSERT_IMPL(a_no_point_while_busy, aclk, aresetn, trig_busy, !s_ready)
    `RTP_ASSERT_NEXT(a_write_starts_update, aclk, aresetn, cfg_start, state_reg == ST_LOAD)
    `RTP_ASSERT_NEXT(a_stage_reaches_output, aclk, aresetn, v3_reg && pipe_en, m_valid)

endmodule

// ----- verif/tb_rotate_translate_points.sv -----
// ============================================================================
// tb_rotate_translate_points
// Self-checking bench for the rotate and translate block. A sine and cosine
// predictor follows every register write, a table of directed point requests
// runs first, then random requests under three idling profiles. Each result
// is compared field by field against the oldest predicted screen point.
// ============================================================================
module tb_rotate_translate_points;
    import rtp_pkg::*;

    localparam int CB        = 16;
    localparam int CFG_W     = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 300;

    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 last;
    } point_t;

    typedef struct packed {
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic                 last;
    } screen_t;

    typedef struct packed {
        logic                 chk;
        point_t               pt;
        screen_t              want;
    } row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [CB-1:0]   s_point_x = '0;
    logic signed [CB-1:0]   s_point_y = '0;
    logic                   s_last_point = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [CB-1:0]   m_screen_x;
    logic signed [CB-1:0]   m_screen_y;
    logic                   m_last_out;

    // Predictor state.
    longint ang_feature, ang_map, north_mode, ctr_x, ctr_y, sin_q15, cos_q15;
    screen_t pending_screens[$];
    int      mismatches;
    int      idle_cycles = 0;
    int      src_idle_pct, snk_idle_pct;

    rotate_translate_points #(.COORD_BITS(CB)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_last_point(s_last_point),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_screen_x(m_screen_x), .m_screen_y(m_screen_y), .m_last_out(m_last_out)
    );

    always #2 aclk = ~aclk;

    function automatic longint sext_val(longint v, int bits);
        longint m;
        m = (longint'(1) << bits) - 1;
        v = v & m;
        if (v >> (bits - 1)) return v - (longint'(1) << bits);
        return v;
    endfunction

    // Series sine and cosine of an angle in the first octant, Q30 floored steps.
    task automatic octant_trig(input longint b, output longint s, output longint c);
        longint unsigned x, x2, t, one;
        one = 64'd1 << 30;
        x  = longint'(b) * 64'd1171271;
        x2 = (x * x) >> 30;
        t = one - x2 / 42;
        t = one - ((x2 * t) >> 30) / 20;
        t = one - ((x2 * t) >> 30) / 6;
        s = longint'((((x * t) >> 30) + (64'd1 << 14)) >> 15);
        t = one - x2 / 56;
        t = one - ((x2 * t) >> 30) / 30;
        t = one - ((x2 * t) >> 30) / 12;
        c = longint'(((one - ((x2 * t) >> 30) / 2) + (64'd1 << 14)) >> 15);
    endtask

    task automatic recompute_rotation();
        longint eff, a, q, r, s, c;
        eff = north_mode ? ang_map - ang_feature : 1440 - ang_feature;
        a = eff % 5760;
        if (a < 0) a += 5760;
        q = a / 1440;
        r = a % 1440;
        if (r <= 720) octant_trig(r, s, c);
        else octant_trig(1440 - r, c, s);
        case (q)
            0: begin sin_q15 = s;  cos_q15 = c;  end
            1: begin sin_q15 = c;  cos_q15 = -s; end
            2: begin sin_q15 = -s; cos_q15 = -c; end
            default: begin sin_q15 = -c; cos_q15 = s; end
        endcase
    endtask

    function automatic longint clamp_coord(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic screen_t rotate_point(point_t p);
        screen_t r;
        longint x, y;
        x = p.px;
        y = p.py;
        r.sx = CB'(clamp_coord(ctr_x + (x * cos_q15 + y * sin_q15) / 32768));
        r.sy = CB'(clamp_coord(ctr_y + (y * cos_q15 - x * sin_q15) / 32768));
        r.last = p.last;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Register write through the configuration channel, block idle.
    // Valid stays high across back-to-back writes; set_config drops it.
    task automatic write_reg(input rtp_reg_t idx, input longint val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FEATURE_ANGLE:    ang_feature = sext_val(val, ANGLE_BITS);
            REG_MAP_ANGLE:        ang_map     = sext_val(val, ANGLE_BITS);
            REG_ANGLE_FROM_NORTH: north_mode  = val & 1;
            REG_CENTER_X:         ctr_x       = sext_val(val, CB);
            default:              ctr_y       = sext_val(val, CB);
        endcase
        recompute_rotation();
    endtask

    task automatic set_config(input longint fa, input longint ma, input longint nm,
                              input longint cx, input longint cy);
        write_reg(REG_FEATURE_ANGLE, fa);
        write_reg(REG_MAP_ANGLE, ma);
        write_reg(REG_ANGLE_FROM_NORTH, nm);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends one point request; an expected screen point is queued on acceptance.
    task automatic send_point(input point_t p, input logic chk, input screen_t want);
        @(negedge aclk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_point_x    <= p.px;
        s_point_y    <= p.py;
        s_last_point <= p.last;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_screens.push_back(chk ? want : rotate_point(p));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_screens.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    function automatic point_t random_point();
        point_t p;
        case ($urandom_range(3))
            0: begin
                p.px = CB'(int'($urandom_range(255)) - 128);
                p.py = CB'(int'($urandom_range(255)) - 128);
            end
            1: begin p.px = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                     p.py = CB'($urandom); end
            default: begin p.px = CB'($urandom); p.py = CB'($urandom); end
        endcase
        p.last = $urandom_range(7) == 0;
        return p;
    endfunction

    // Result checking and receiver stalls.
    always @(posedge aclk) begin
        screen_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_screens.size() == 0) begin
                report_mismatch("unexpected result", m_screen_x, 0);
            end else begin
                want = pending_screens.pop_front();
                if (m_screen_x !== want.sx) report_mismatch("screen_x", m_screen_x, want.sx);
                if (m_screen_y !== want.sy) report_mismatch("screen_y", m_screen_y, want.sy);
                if (m_last_out !== want.last) report_mismatch("last_out", m_last_out, want.last);
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= !(snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct);
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        row_t    rows[$];
        row_t    rw;
        screen_t none;
        int      prof;
        none = '0;
        mismatches = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        ang_feature = 0; ang_map = 0; north_mode = 1; ctr_x = 0; ctr_y = 0;
        sin_q15 = 0; cos_q15 = 32768;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // After reset the rotation is zero and the center is the origin.
        rows.push_back({1'b1, {16'sd100, -16'sd7, 1'b0}, {16'sd100, -16'sd7, 1'b0}});
        rows.push_back({1'b1, {16'sh7fff, 16'sh8000, 1'b1}, {16'sh7fff, 16'sh8000, 1'b1}});
        rows.push_back({1'b1, {16'sh0000, 16'sh0000, 1'b0}, {16'sh0000, 16'sh0000, 1'b0}});
        rows.push_back({1'b1, {16'shffff, 16'sh0001, 1'b1}, {16'shffff, 16'sh0001, 1'b1}});
        foreach (rows[i]) send_point(rows[i].pt, rows[i].chk, rows[i].want);
        wait_drained();

        // Directed settings: quadrants, octant boundary, out-of-range angles,
        // heading off, and extreme centers that saturate.
        rows.delete();
        rows.push_back({1'b0, {16'sh7fff, 16'sh7fff, 1'b0}, none});
        rows.push_back({1'b0, {16'sh8000, 16'sh8000, 1'b1}, none});
        rows.push_back({1'b0, {16'sh8000, 16'sh7fff, 1'b0}, none});
        rows.push_back({1'b0, {16'sd1000, -16'sd333, 1'b1}, none});
        for (int k = 0; k < 7; k++) begin
            case (k)
                0: set_config(0, 1440, 1, 0, 0);
                1: set_config(-720, 0, 1, 32767, -32768);
                2: set_config(5760, -5760, 0, -32768, 32767);
                3: set_config(16'h1fff, 16'h2000, 1, 100, -100);
                4: set_config(2880, 0, 1, 32767, 32767);
                5: set_config(1440, 0, 0, -32768, -32768);
                default: set_config(721, 3, 1, 5, 5);
            endcase
            foreach (rows[i]) send_point(rows[i].pt, rows[i].chk, rows[i].want);
            wait_drained();
        end

        // Random part in three idling profiles with random settings between.
        for (prof = 0; prof < 3; prof++) begin
            src_idle_pct = (prof == 0) ? 13 : (prof == 1) ? 60 : 0;
            snk_idle_pct = (prof == 0) ? 60 : (prof == 1) ? 13 : 0;
            for (int blk = 0; blk < 8; blk++) begin
                if (blk % 4 == 3) begin
                    set_config(longint'($urandom), longint'($urandom), longint'($urandom),
                               longint'($urandom), longint'($urandom));
                end else begin
                    set_config(longint'($urandom_range(11520)) - 5760,
                               longint'($urandom_range(11520)) - 5760,
                               longint'($urandom_range(1)),
                               longint'($urandom_range(2000)) - 1000,
                               longint'($urandom_range(2000)) - 1000);
                end
                repeat (66) send_point(random_point(), 1'b0, none);
                wait_drained();
            end
        end

        repeat (DRAIN_CYC) @(negedge aclk);
        if (mismatches == 0 && pending_screens.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- rotate_translate_points.f -----
+incdir+sv
sv/rtp_pkg.sv
sv/rotate_translate_points.sv
verif/tb_rotate_translate_points.sv
